@@ rtl/rti_pkg.sv @@
// package for the ranked table insertion block: sizes, register codes, states, case folding
package rti_pkg;
  localparam int unsigned NumTablesDef  = 32;
  localparam int unsigned TableSlotsDef = 256;
  localparam int unsigned NameBytesDef  = 16;

  localparam logic CfgThreshold = 1'b0;
  localparam logic CfgLength    = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StClear, StScanRd, StScanChk, StDecide, StShiftRd, StShiftWr, StWrite, StDone
  } state_e;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction
endpackage

@@ rtl/rti_name_cmp.sv @@
// case-folded name compare that stops at the first zero byte
module rti_name_cmp import rti_pkg::*; #(
  parameter int unsigned NameBytes = NameBytesDef
) (
  input  logic [63:0] a_first_i,
  input  logic [63:0] a_last_i,
  input  logic [63:0] b_first_i,
  input  logic [63:0] b_last_i,
  output logic        match_o
);
  logic [127:0] a_w, b_w;
  logic [15:0]  eq, zero;
  logic         m, stop;

  assign a_w = {a_last_i, a_first_i};
  assign b_w = {b_last_i, b_first_i};

  for (genvar k = 0; k < 16; k++) begin : g_byte
    assign eq[k]   = fold_case(a_w[8*k +: 8]) == fold_case(b_w[8*k +: 8]);
    assign zero[k] = fold_case(a_w[8*k +: 8]) == 8'h00;
  end

  always_comb begin
    m = 1'b1;
    stop = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (k < NameBytes && !stop) begin
        if (!eq[k]) begin
          m = 1'b0;
          stop = 1'b1;
        end else if (zero[k]) begin
          stop = 1'b1;
        end
      end
    end
    match_o = m;
  end
endmodule

@@ rtl/ranked_table_insert.sv @@
// ranked table insertion block: memory-based scan, shift and write of sorted tables
// operation: a scan of the table from its last entry, a shift of the entries between the old and
//   new position, then the write of the new entry; the single memory port serves every step
// throughput: one request at a time; busy stays high until the result strobe
// reset: a clearing pass zeroes every memory entry after reset, with busy high
// the result strobe lasts one cycle and the receiver cannot stall it
module ranked_table_insert import rti_pkg::*; #(
  parameter int unsigned NUM_TABLES  = NumTablesDef,
  parameter int unsigned TABLE_SLOTS = TableSlotsDef,
  parameter int unsigned NAME_BYTES  = NameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [4:0]  table_select_i,
  input  logic [63:0] name_first_bytes_i,
  input  logic [63:0] name_last_bytes_i,
  input  logic [31:0] score_i,
  input  logic [15:0] status_bits_i,
  input  logic [7:0]  level_value_i,
  input  logic [7:0]  class_value_i,
  output logic        done_o,
  output logic        changed_o,
  output logic [7:0]  written_slot_o
);
  localparam int unsigned SW    = $clog2(TABLE_SLOTS);
  localparam int unsigned TW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned AW    = SW + TW;
  localparam int unsigned DEPTH = NUM_TABLES * (1 << SW);
  localparam int unsigned EW    = 192;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q, wdata;
  logic [AW-1:0] addr;
  logic          we;

  state_e state_q, state_d;
  logic [31:0] thr_q;
  logic [8:0]  len_q;
  logic [AW:0] clr_q, clr_d;
  logic [TW-1:0] tab_q, tab_d;
  logic [63:0] nf_q, nl_q;
  logic [31:0] sc_q;
  logic [31:0] at_q;
  logic [SW:0] len_c, i_q, i_d, new_q, new_d, old_q, old_d, tgt_q, tgt_d;
  logic        hi_found_q, hi_found_d, old_found_q, old_found_d, chg_q, chg_d;
  logic        below_q, below_d;
  logic        match;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rd_q <= mem[addr];
  end

  rti_name_cmp #(.NameBytes(NAME_BYTES)) u_cmp (
    .a_first_i(rd_q[63:0]), .a_last_i(rd_q[127:64]),
    .b_first_i(nf_q), .b_last_i(nl_q), .match_o(match)
  );

  always_comb begin
    if (len_q == 9'd0) len_c = (SW+1)'(1);
    else if ({23'd0, len_q} > TABLE_SLOTS) len_c = (SW+1)'(TABLE_SLOTS);
    else len_c = (SW+1)'(len_q);
  end

  assign busy        = state_q != StIdle;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
      len_q <= 9'd256;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgThreshold) thr_q <= cfg_data_i;
      if (cfg_index_i == CfgLength) len_q <= cfg_data_i[8:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tab_q <= tab_d;
    i_q <= i_d;
    new_q <= new_d;
    old_q <= old_d;
    tgt_q <= tgt_d;
    hi_found_q <= hi_found_d;
    old_found_q <= old_found_d;
    chg_q <= chg_d;
    below_q <= below_d;
    if (state_q == StIdle && start) begin
      nf_q <= name_first_bytes_i;
      nl_q <= name_last_bytes_i;
      sc_q <= score_i;
      at_q <= {class_value_i, level_value_i, status_bits_i};
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:   if (clr_q == (AW+1)'(DEPTH - 1)) state_d = StIdle;
      StIdle:
        if (start) begin
          if ({27'd0, table_select_i} >= NUM_TABLES || name_first_bytes_i[7:0] == 8'h00)
            state_d = StDone;
          else state_d = StScanRd;
        end
      StScanRd:  state_d = StScanChk;
      StScanChk: state_d = (i_q == '0) ? StDecide : StScanRd;
      StDecide:  state_d = chg_d ? ((i_d == new_d) ? StWrite : StShiftRd) : StDone;
      StShiftRd: state_d = StShiftWr;
      StShiftWr: state_d = (i_d == tgt_q) ? StWrite : StShiftRd;
      StWrite:   state_d = StDone;
      StDone:    state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    logic [SW:0] np, op, nxt;
    logic        oot;
    clr_d = clr_q;
    tab_d = tab_q;
    i_d = i_q;
    new_d = new_q;
    old_d = old_q;
    tgt_d = tgt_q;
    hi_found_d = hi_found_q;
    old_found_d = old_found_q;
    chg_d = chg_q;
    below_d = below_q;
    we = 1'b0;
    addr = {tab_q, i_q[SW-1:0]};
    wdata = rd_q;
    np = '0;
    op = '0;
    oot = 1'b0;
    nxt = (i_q < tgt_q) ? i_q + 1'b1 : i_q - 1'b1;
    unique case (state_q)
      StClear: begin
        we = 1'b1;
        addr = clr_q[AW-1:0];
        wdata = '0;
        clr_d = clr_q + 1'b1;
      end
      StIdle: begin
        chg_d = 1'b0;
        tab_d = TW'(table_select_i);
        i_d = len_c - 1'b1;
        new_d = '0;
        hi_found_d = 1'b0;
        old_found_d = 1'b0;
        below_d = score_i < thr_q;
      end
      StScanRd: ;
      StScanChk: begin
        if (!hi_found_q && !below_q && rd_q[159:128] > sc_q) begin
          hi_found_d = 1'b1;
          new_d = match ? i_q : i_q + 1'b1;
        end
        if (!old_found_q && match) begin
          old_found_d = 1'b1;
          old_d = i_q;
        end
        if (i_q != '0) i_d = i_q - 1'b1;
      end
      StDecide: begin
        op = old_found_q ? old_q : len_c - 1'b1;
        np = new_q;
        if (below_q || new_q >= len_c) begin
          np = len_c - 1'b1;
          oot = 1'b1;
        end
        chg_d = !(op == len_c - 1'b1 && oot);
        if (np > op && !oot) np = np - 1'b1;
        new_d = np;
        tgt_d = np;
        i_d = op;
      end
      StShiftRd: addr = {tab_q, nxt[SW-1:0]};
      StShiftWr: begin
        we = 1'b1;
        i_d = nxt;
      end
      StWrite: begin
        we = 1'b1;
        addr = {tab_q, new_q[SW-1:0]};
        wdata = {at_q, sc_q, nl_q, nf_q};
      end
      StDone: ;
      default: ;
    endcase
  end

  assign done_o = state_q == StDone;
  assign changed_o = done_o && chg_q;
  assign written_slot_o = (done_o && chg_q) ? 8'(new_q) : 8'd0;

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done twice");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done while idle");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !we) else $error("write while idle");
endmodule

@@ tb/ranked_table_insert_tb.sv @@
// testbench for the ranked table insertion block: directed and random requests checked against a predictor
module ranked_table_insert_tb;
  import rti_pkg::*;

  localparam int unsigned NTab  = NumTablesDef;
  localparam int unsigned NSlot = TableSlotsDef;
  localparam int unsigned NByte = NameBytesDef;
  localparam int unsigned WatchdogLimit = 40000;

  typedef struct packed {
    logic       changed;
    logic [7:0] slot;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CfgThreshold;
  logic [31:0] cfg_data_i = '0;
  logic [4:0]  table_select_i = '0;
  logic [63:0] name_first_bytes_i = '0;
  logic [63:0] name_last_bytes_i = '0;
  logic [31:0] score_i = '0;
  logic [15:0] status_bits_i = '0;
  logic [7:0]  level_value_i = '0;
  logic [7:0]  class_value_i = '0;
  logic        done_o;
  logic        changed_o;
  logic [7:0]  written_slot_o;

  ranked_table_insert uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [63:0] tbl_first [NTab*NSlot];
  logic [63:0] tbl_last  [NTab*NSlot];
  logic [31:0] tbl_score [NTab*NSlot];
  logic [31:0] tbl_attr  [NTab*NSlot];
  logic [31:0] threshold_q;
  logic [8:0]  length_q;

  outcome_t    pending_outcomes[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          sender_idle_pct = 0;

  logic [7:0]  name_pool [12][16];
  int          name_len  [12];

  function automatic logic [7:0] byte_at(logic [63:0] lo, logic [63:0] hi, int k);
    return (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  function automatic bit same_name(int idx, logic [63:0] lo, logic [63:0] hi);
    logic [7:0] a, b;
    for (int k = 0; k < NByte; k++) begin
      a = lower(byte_at(tbl_first[idx], tbl_last[idx], k));
      b = lower(byte_at(lo, hi, k));
      if (a != b) return 0;
      if (a == 8'h00) return 1;
    end
    return 1;
  endfunction

  function automatic outcome_t rank_entry(logic [4:0] tsel, logic [63:0] lo, logic [63:0] hi,
                                          logic [31:0] sc, logic [31:0] attr);
    outcome_t res;
    int len, newpos, oldpos, base, dir;
    bit past_end;
    res = '0;
    past_end = 0;
    if (tsel >= NTab || lo[7:0] == 8'h00) return res;
    len = (length_q == 0) ? 1 : (length_q > NSlot) ? NSlot : length_q;
    base = tsel * NSlot;
    if (sc < threshold_q) begin
      newpos = -1;
    end else begin
      newpos = 0;
      for (int i = len - 1; i >= 0; i--) begin
        if (tbl_score[base+i] > sc) begin
          newpos = same_name(base + i, lo, hi) ? i : i + 1;
          break;
        end
      end
    end
    oldpos = -1;
    for (int i = len - 1; i >= 0; i--) begin
      if (same_name(base + i, lo, hi)) begin
        oldpos = i;
        break;
      end
    end
    if (oldpos < 0) oldpos = len - 1;
    if (newpos < 0 || newpos >= len) begin
      newpos = len - 1;
      past_end = 1;
    end
    if (oldpos == len - 1 && past_end) return res;
    if (newpos > oldpos && !past_end) newpos--;
    dir = (newpos > oldpos) ? 1 : -1;
    for (int i = oldpos; i != newpos; i += dir) begin
      tbl_first[base+i] = tbl_first[base+i+dir];
      tbl_last[base+i]  = tbl_last[base+i+dir];
      tbl_score[base+i] = tbl_score[base+i+dir];
      tbl_attr[base+i]  = tbl_attr[base+i+dir];
    end
    tbl_first[base+newpos] = lo;
    tbl_last[base+newpos]  = hi;
    tbl_score[base+newpos] = sc;
    tbl_attr[base+newpos]  = attr;
    res.changed = 1'b1;
    res.slot = newpos[7:0];
    return res;
  endfunction

  task automatic send_entry(logic [4:0] tsel, logic [63:0] lo, logic [63:0] hi,
                            logic [31:0] sc, logic [15:0] st, logic [7:0] lv, logic [7:0] cl);
    table_select_i     <= tsel;
    name_first_bytes_i <= lo;
    name_last_bytes_i  <= hi;
    score_i            <= sc;
    status_bits_i      <= st;
    level_value_i      <= lv;
    class_value_i      <= cl;
    start              <= 1'b1;
    do @(posedge clk_i); while (busy);
    pending_outcomes.push_back(rank_entry(tsel, lo, hi, sc, {cl, lv, st}));
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0 || busy) @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgThreshold) threshold_q = val;
    else length_q = val[8:0];
  endtask

  // builds a name from the pool with random case and junk after the terminator
  task automatic pick_name(int p, output logic [63:0] lo, output logic [63:0] hi);
    logic [7:0] c;
    for (int k = 0; k < 16; k++) begin
      if (k < name_len[p]) begin
        c = name_pool[p][k];
        if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1)) c = c - 8'h20;
      end else if (k == name_len[p]) begin
        c = 8'h00;
      end else begin
        c = 8'($urandom_range(0, 255));
      end
      if (k < 8) lo[8*k +: 8] = c;
      else hi[8*(k-8) +: 8] = c;
    end
  endtask

  task automatic send_random(int tables, int score_max);
    logic [63:0] lo, hi;
    logic [31:0] sc;
    logic [4:0]  tsel;
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
    end else if (r < 10) begin
      lo = {$urandom, $urandom} & ~64'hff;
      hi = {$urandom, $urandom};
    end else begin
      pick_name($urandom_range(0, 11), lo, hi);
    end
    r = $urandom_range(0, 99);
    if (r < 5) sc = '1;
    else if (r < 10) sc = '0;
    else if (r < 18) sc = $urandom;
    else sc = $urandom_range(0, score_max);
    tsel = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(0, tables - 1)) : 5'($urandom);
    send_entry(tsel, lo, hi, sc, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    send_entry(5'd0, 64'h41, 64'h0, 32'd100, 16'hffff, 8'hff, 8'hff);
    send_entry(5'd0, 64'h62, 64'h0, 32'd200, 16'h0, 8'h0, 8'h0);
    send_entry(5'd0, 64'h61, 64'h0, 32'd300, 16'h1234, 8'h56, 8'h78);
    send_entry(5'd0, 64'h42, 64'h0, 32'd50, 16'h1, 8'h2, 8'h3);
    send_entry(5'd0, 64'h0, 64'h0, 32'd500, 16'h0, 8'h0, 8'h0);
    send_entry(5'd31, '1, '1, '1, 16'hffff, 8'hff, 8'hff);
    send_entry(5'd31, '1, '0, '0, 16'h0, 8'h0, 8'h0);
    send_entry(5'd31, 64'hffff_ffff_ffff_ff00, '1, '1, 16'h0, 8'h0, 8'h0);
    send_entry(5'd1, 64'h00_ff_6f_6f_46, 64'h5a, 32'd10, 16'h0, 8'h0, 8'h0);
    send_entry(5'd1, 64'h77_00_4f_4f_66, 64'h0, 32'd10, 16'h0, 8'h0, 8'h0);
    write_reg(CfgThreshold, 32'd150);
    send_entry(5'd0, 64'h61, 64'h0, 32'd20, 16'h0, 8'h0, 8'h0);
    send_entry(5'd0, 64'h7a, 64'h0, 32'd20, 16'h0, 8'h0, 8'h0);
    send_entry(5'd0, 64'h41, 64'h0, 32'd149, 16'h0, 8'h0, 8'h0);
    write_reg(CfgThreshold, 32'hffff_ffff);
    send_entry(5'd0, 64'h62, 64'h0, 32'hffff_fffe, 16'h0, 8'h0, 8'h0);
    send_entry(5'd0, 64'h62, 64'h0, 32'hffff_ffff, 16'h0, 8'h0, 8'h0);
    write_reg(CfgThreshold, 32'd0);
  endtask

  task automatic test_length_extremes();
    write_reg(CfgLength, 32'd0);
    send_entry(5'd2, 64'h71, 64'h0, 32'd5, 16'h0, 8'h0, 8'h0);
    send_entry(5'd2, 64'h72, 64'h0, 32'd9, 16'h0, 8'h0, 8'h0);
    send_entry(5'd2, 64'h73, 64'h0, 32'd1, 16'h0, 8'h0, 8'h0);
    write_reg(CfgLength, 32'h0000_01ff);
    send_entry(5'd2, 64'h74, 64'h0, 32'd0, 16'h0, 8'h0, 8'h0);
    send_entry(5'd2, 64'h71, 64'h0, 32'd3, 16'h0, 8'h0, 8'h0);
    write_reg(CfgLength, 32'hffff_fe02);
    send_entry(5'd2, 64'h72, 64'h0, 32'd0, 16'h0, 8'h0, 8'h0);
    send_entry(5'd2, 64'h75, 64'h0, 32'd100, 16'h0, 8'h0, 8'h0);
  endtask

  task automatic test_random_phase(int items, int idle_pct);
    int lens[5] = '{3, 8, 1, 16, 5};
    sender_idle_pct = idle_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) begin
        write_reg(CfgLength, lens[$urandom_range(0, 4)]);
        write_reg(CfgThreshold, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0);
      end
      send_random(4, 24);
    end
    write_reg(CfgLength, 32'd256);
    for (int i = 0; i < 6; i++) send_random(2, 24);
  endtask

  always @(posedge clk_i) begin
    if (done_o) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no request pending: changed %0d slot %0d", changed_o,
               written_slot_o);
        error_count++;
      end else begin
        outcome_t exp_o;
        exp_o = pending_outcomes.pop_front();
        if (changed_o !== exp_o.changed) begin
          $error("changed: expected %0d, actual %0d", exp_o.changed, changed_o);
          error_count++;
        end
        if (written_slot_o !== exp_o.slot) begin
          $error("written_slot: expected %0d, actual %0d", exp_o.slot, written_slot_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NTab * NSlot; i++) begin
      tbl_first[i] = '0;
      tbl_last[i]  = '0;
      tbl_score[i] = '0;
      tbl_attr[i]  = '0;
    end
    threshold_q = '0;
    length_q = 9'd256;
    for (int p = 0; p < 12; p++) begin
      name_len[p] = $urandom_range(1, 16);
      for (int k = 0; k < 16; k++)
        name_pool[p][k] = (k < name_len[p]) ?
          (($urandom_range(0, 5) == 0) ? 8'($urandom_range(8'h30, 8'h39))
                                       : 8'($urandom_range(8'h61, 8'h7a))) : 8'h00;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_length_extremes();
    test_random_phase(180, 11);
    test_random_phase(180, 78);
    test_random_phase(180, 0);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
